FILE: rtl/core/fgd_pkg.sv
// shared constants and types for the fir gain decimator chain
package fgd_pkg;

    localparam int TAPS            = 16;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int COEF_WIDTH      = 32;
    localparam int FRAC_SHIFT      = 15;
    localparam int GAIN_WIDTH      = 16;
    localparam int DECIM_WIDTH     = 5;
    localparam int PHASE_WIDTH     = 4;
    localparam int MAX_FACTOR      = 16;
    localparam int TAP_INDEX_WIDTH = 4;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN  = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DECIM = 1'd1;

    localparam logic [0:0] MODE_SAMPLE = 1'b0;
    localparam logic [0:0] MODE_COEF   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILTER,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic coef_we;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/fgd_cell.sv
// one filter cell: a delay entry, its coefficient and a multiply-add on the partial sum
module fgd_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fgd_pkg::cell_ctrl_t                   ctrl,
    input  logic signed [fgd_pkg::SAMPLE_WIDTH-1:0] delay_in,
    input  logic signed [fgd_pkg::COEF_WIDTH-1:0]   coef_in,
    input  logic [fgd_pkg::COEF_WIDTH-1:0]          sum_in,
    input  logic                                  tok_in,
    output logic signed [fgd_pkg::SAMPLE_WIDTH-1:0] delay_out,
    output logic [fgd_pkg::COEF_WIDTH-1:0]          sum_out,
    output logic                                  tok_out
);
    import fgd_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0]            delay_reg, delay_next;
    logic signed [COEF_WIDTH-1:0]              coef_reg, coef_next;
    logic [COEF_WIDTH-1:0]                     sum_reg, sum_next;
    logic                                      tok_reg;
    logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] prod;

    assign prod = delay_reg * coef_reg;

    always_comb begin
        delay_next = delay_reg;
        if (ctrl.shift) begin
            delay_next = ctrl.clear ? '0 : delay_in;
        end
        coef_next = ctrl.coef_we ? coef_in : coef_reg;
        // accumulator wraps at its own width
        sum_next = tok_in ? sum_in + prod[COEF_WIDTH-1:0] : sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= '0;
            coef_reg  <= '0;
            tok_reg   <= 1'b0;
        end else begin
            delay_reg <= delay_next;
            coef_reg  <= coef_next;
            tok_reg   <= tok_in;
        end
        sum_reg <= sum_next;
    end

    assign delay_out = delay_reg;
    assign sum_out   = sum_reg;
    assign tok_out   = tok_reg;

endmodule

FILE: rtl/core/fgd_tail.sv
// output scaling: drop the fraction bits of the filter sum and apply the gain
module fgd_tail (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [fgd_pkg::COEF_WIDTH-1:0]          sum_in,
    input  logic                                  tok_in,
    input  logic signed [fgd_pkg::GAIN_WIDTH-1:0]   gain,
    output logic signed [fgd_pkg::SAMPLE_WIDTH-1:0] gained,
    output logic                                  gained_valid
);
    import fgd_pkg::*;

    localparam int EXT_WIDTH = COEF_WIDTH + SAMPLE_WIDTH + FRAC_SHIFT;

    logic signed [EXT_WIDTH-1:0]               ext;
    logic signed [EXT_WIDTH-1:0]               shifted;
    logic signed [SAMPLE_WIDTH-1:0]            filt;
    logic signed [SAMPLE_WIDTH+GAIN_WIDTH-1:0] prod;
    logic signed [SAMPLE_WIDTH-1:0]            gained_reg, gained_next;
    logic                                      valid_reg;

    assign ext     = {{(EXT_WIDTH-COEF_WIDTH){sum_in[COEF_WIDTH-1]}}, sum_in};
    assign shifted = ext >>> FRAC_SHIFT;
    assign filt    = shifted[SAMPLE_WIDTH-1:0];
    assign prod    = filt * gain;

    always_comb begin
        gained_next = tok_in ? prod[SAMPLE_WIDTH-1:0] : gained_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= tok_in;
        end
        gained_reg <= gained_next;
    end

    assign gained       = gained_reg;
    assign gained_valid = valid_reg;

endmodule

FILE: rtl/core/fir_gain_decimator_chain.sv
// top level: fir filter over a chain of cells, gain stage and decimator
// A coefficient word (mode 1) is taken and the block is ready again at once. A
// sample word (mode 0) shifts into the delay line in the cycle it is accepted, then a partial
// sum travels down the row of TAPS cells, one multiply-add per cell per cycle, a scaling stage
// applies the gain, and the result is handed to the output register. The next word is taken
// only after the sum has walked the start register, the cell row and the scaling stage; for
// a sample whose result the decimator keeps, only after that result has also been written to
// the output register. A result waiting in the output register does not hold up the next
// sample until that sample's own result is ready; from then on the input stays closed until
// m_ready takes the waiting word. block_start clears the delay line and the decimation phase
// before its sample is stored. No clearing pass is needed after reset.
module fir_gain_decimator_chain (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [fgd_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [fgd_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_mode,
    input  logic signed [fgd_pkg::SAMPLE_WIDTH-1:0] s_sample_value,
    input  logic                                  s_block_start,
    input  logic [fgd_pkg::TAP_INDEX_WIDTH-1:0]     s_tap_index,
    input  logic signed [fgd_pkg::COEF_WIDTH-1:0]   s_coef_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [fgd_pkg::SAMPLE_WIDTH-1:0] m_result_sample
);
    import fgd_pkg::*;

    state_t                   state_reg, state_next;
    logic signed [GAIN_WIDTH-1:0] gain_reg, gain_next;
    logic [DECIM_WIDTH-1:0]   decim_reg, decim_next;
    logic [PHASE_WIDTH-1:0]   phase_reg, phase_next;
    logic                     emit_reg, emit_next;
    logic                     start_reg, start_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] m_data_reg, m_data_next;

    logic                     accept;
    logic                     take_sample;
    logic                     take_coef;
    logic [DECIM_WIDTH-1:0]   factor;
    logic [PHASE_WIDTH-1:0]   phase_base;
    logic [PHASE_WIDTH:0]     phase_inc;

    logic signed [SAMPLE_WIDTH-1:0] delay_chain [TAPS+1];
    logic [COEF_WIDTH-1:0]          sum_chain   [TAPS+1];
    logic                           tok_chain   [TAPS+1];
    cell_ctrl_t                     cell_ctrl   [TAPS];

    logic signed [SAMPLE_WIDTH-1:0] gained;
    logic                           gained_valid;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign take_sample = accept && (s_mode == MODE_SAMPLE);
    assign take_coef   = accept && (s_mode == MODE_COEF);

    // zero acts as one, anything above the maximum as the maximum
    always_comb begin
        if (decim_reg == '0) begin
            factor = DECIM_WIDTH'(1);
        end else if (decim_reg > DECIM_WIDTH'(MAX_FACTOR)) begin
            factor = DECIM_WIDTH'(MAX_FACTOR);
        end else begin
            factor = decim_reg;
        end
    end

    assign phase_base = s_block_start ? '0 : phase_reg;
    assign phase_inc  = {1'b0, phase_base} + 1'b1;

    assign delay_chain[0] = s_sample_value;
    assign sum_chain[0]   = '0;
    assign tok_chain[0]   = start_reg;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        always_comb begin
            cell_ctrl[k].shift   = take_sample;
            cell_ctrl[k].clear   = (k != 0) && s_block_start;
            cell_ctrl[k].coef_we = take_coef &&
                ({{(32-TAP_INDEX_WIDTH){1'b0}}, s_tap_index} == 32'(k));
        end

        fgd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (cell_ctrl[k]),
            .delay_in  (delay_chain[k]),
            .coef_in   (s_coef_value),
            .sum_in    (sum_chain[k]),
            .tok_in    (tok_chain[k]),
            .delay_out (delay_chain[k+1]),
            .sum_out   (sum_chain[k+1]),
            .tok_out   (tok_chain[k+1])
        );
    end

    fgd_tail u_tail (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sum_in       (sum_chain[TAPS]),
        .tok_in       (tok_chain[TAPS]),
        .gain         (gain_reg),
        .gained       (gained),
        .gained_valid (gained_valid)
    );

    always_comb begin
        state_next   = state_reg;
        gain_next    = gain_reg;
        decim_next   = decim_reg;
        phase_next   = phase_reg;
        emit_next    = emit_reg;
        start_next   = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cfg_wen) begin
            unique case (cfg_index)
                REG_GAIN:  gain_next  = cfg_wdata[GAIN_WIDTH-1:0];
                REG_DECIM: decim_next = cfg_wdata[DECIM_WIDTH-1:0];
                default:   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (take_sample) begin
                    emit_next  = (phase_base == '0);
                    phase_next = (phase_inc >= factor) ? '0
                                                       : phase_inc[PHASE_WIDTH-1:0];
                    start_next = 1'b1;
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER: begin
                if (gained_valid) begin
                    state_next = emit_reg ? ST_DELIVER : ST_IDLE;
                end
            end
            ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = gained;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_WIDTH'(1);
            decim_reg   <= DECIM_WIDTH'(2);
            phase_reg   <= '0;
            emit_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            decim_reg   <= decim_next;
            phase_reg   <= phase_next;
            emit_reg    <= emit_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_sample = m_data_reg;

endmodule

FILE: rtl/core/fgd_checker.sv
// port-level checks for the fir gain decimator chain, bound to the top level
module fgd_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  s_mode,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [fgd_pkg::SAMPLE_WIDTH-1:0] m_result_sample
);
    import fgd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_sample))
        else $error("result word changed or dropped while stalled");

    // no result shows right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a sample word keeps the input closed while it runs through the cells
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_SAMPLE) |=> !s_ready)
        else $error("input ready in the cycle after a sample word");

    // the input is ready again in the cycle after a coefficient word
    a_coef_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_mode == MODE_COEF) |=> s_ready)
        else $error("input not ready after a coefficient word");

endmodule

bind fir_gain_decimator_chain fgd_checker u_fgd_checker (.*);
